FILE: src/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, phase codes and helpers for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Configuration register indexes.
  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [11:0] HALF_PERIOD_RESET = 12'd50;
  localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

  // Command codes.
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_STOP  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // Sequencer phase codes.
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_ST_A    = 4'd1;
  localparam logic [3:0] PH_ST_B    = 4'd2;
  localparam logic [3:0] PH_SP_A    = 4'd3;
  localparam logic [3:0] PH_SP_B    = 4'd4;
  localparam logic [3:0] PH_WR_SET  = 4'd5;
  localparam logic [3:0] PH_WR_HIGH = 4'd6;
  localparam logic [3:0] PH_WR_LOW  = 4'd7;
  localparam logic [3:0] PH_AK_WAIT = 4'd8;
  localparam logic [3:0] PH_AK_POLL = 4'd9;
  localparam logic [3:0] PH_RD_LOW  = 4'd10;
  localparam logic [3:0] PH_RD_HIGH = 4'd11;
  localparam logic [3:0] PH_RA_LOW  = 4'd12;
  localparam logic [3:0] PH_RA_HIGH = 4'd13;

  typedef struct packed {
    logic listen;
    logic sda;
    logic scl;
  } line_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [1:0]  action;
    logic [7:0]  tx_byte;
    logic        send_ack;
    logic        sda_in;
  } tick_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [2:0]  bit_index;
    logic [7:0]  shift_data;
    logic [11:0] wait_count;
    logic [7:0]  poll_count;
    logic        ack_choice;
    line_t       lines;
    logic [7:0]  rx_hold;
    logic        nack_hold;
  } eng_state_t;

  // A released SDA always reads back as a driven one.
  function automatic line_t drive(input logic scl, input logic sda, input logic listen);
    line_t l;
    l.scl    = scl;
    l.sda    = sda | listen;
    l.listen = listen;
    return l;
  endfunction

endpackage

FILE: src/i2cm_fsm.sv
// ----------------------------------------------------------------------------
// i2cm_fsm
// Next-state logic of the engine: advances the bus sequencer by one tick.
// ----------------------------------------------------------------------------
module i2cm_fsm (
  input  i2cm_pkg::eng_state_t cur,
  input  i2cm_pkg::tick_t      tick,
  input  logic [11:0]          half_period,
  input  logic [7:0]           ack_timeout,
  output i2cm_pkg::eng_state_t nxt,
  output logic                 done
);
  import i2cm_pkg::*;

  logic [11:0] period;
  logic [11:0] wc_tick;
  logic        expired;
  logic [11:0] wc_after;

  // A zero half period behaves as one tick.
  assign period   = (half_period == 12'd0) ? 12'd1 : half_period;
  assign wc_tick  = cur.wait_count + 12'd1;
  assign expired  = (wc_tick >= period);
  assign wc_after = expired ? 12'd0 : wc_tick;

  always_comb begin
    nxt  = cur;
    done = 1'b0;
    case (cur.phase)
      PH_IDLE: begin
        if (tick.cmd_valid) begin
          nxt.wait_count = 12'd0;
          nxt.bit_index  = 3'd0;
          case (tick.action)
            ACT_START: begin
              nxt.lines = drive(1'b1, 1'b1, 1'b0);
              nxt.phase = PH_ST_A;
            end
            ACT_STOP: begin
              nxt.lines = drive(1'b0, 1'b0, 1'b0);
              nxt.phase = PH_SP_A;
            end
            ACT_WRITE: begin
              nxt.shift_data = tick.tx_byte;
              nxt.lines      = drive(1'b0, tick.tx_byte[7], 1'b0);
              nxt.phase      = PH_WR_SET;
            end
            default: begin
              nxt.shift_data = 8'd0;
              nxt.ack_choice = tick.send_ack;
              nxt.lines      = drive(1'b0, 1'b1, 1'b1);
              nxt.phase      = PH_RD_LOW;
            end
          endcase
        end
      end
      PH_ST_A: begin
        nxt.wait_count = wc_after;
        if (expired) begin
          nxt.lines = drive(1'b1, 1'b0, 1'b0);
          nxt.phase = PH_ST_B;
        end
      end
      PH_ST_B: begin
        nxt.wait_count = wc_after;
        if (expired) begin
          nxt.lines = drive(1'b0, 1'b0, 1'b0);
          nxt.phase = PH_IDLE;
          done      = 1'b1;
        end
      end
      PH_SP_A: begin
        nxt.wait_count = wc_after;
        if (expired) begin
          nxt.lines = drive(1'b1, 1'b0, 1'b0);
          nxt.phase = PH_SP_B;
        end
      end
      PH_SP_B: begin
        nxt.wait_count = wc_after;
        if (expired) begin
          nxt.lines = drive(1'b1, 1'b1, 1'b0);
          nxt.phase = PH_IDLE;
          done      = 1'b1;
        end
      end
      PH_WR_SET: begin
        nxt.wait_count = wc_after;
        if (expired) begin
          nxt.lines = drive(1'b1, cur.shift_data[7], 1'b0);
          nxt.phase = PH_WR_HIGH;
        end
      end
      PH_WR_HIGH: begin
        nxt.wait_count = wc_after;
        if (expired) begin
          nxt.lines = drive(1'b0, cur.shift_data[7], 1'b0);
          nxt.phase = PH_WR_LOW;
        end
      end
      PH_WR_LOW: begin
        nxt.wait_count = wc_after;
        if (expired) begin
          if (cur.bit_index == 3'd7) begin
            nxt.lines = drive(1'b1, 1'b1, 1'b1);
            nxt.phase = PH_AK_WAIT;
          end else begin
            nxt.bit_index  = cur.bit_index + 3'd1;
            nxt.shift_data = {cur.shift_data[6:0], 1'b0};
            nxt.lines      = drive(1'b0, cur.shift_data[6], 1'b0);
            nxt.phase      = PH_WR_SET;
          end
        end
      end
      PH_AK_WAIT: begin
        nxt.wait_count = wc_after;
        if (expired) begin
          nxt.poll_count = 8'd0;
          nxt.phase      = PH_AK_POLL;
        end
      end
      PH_AK_POLL: begin
        if (!tick.sda_in) begin
          nxt.lines     = drive(1'b0, 1'b1, 1'b1);
          nxt.nack_hold = 1'b0;
          nxt.phase     = PH_IDLE;
          done          = 1'b1;
        end else if (cur.poll_count >= ack_timeout) begin
          // No acknowledge in time: flag it and release the bus with a stop.
          nxt.nack_hold  = 1'b1;
          nxt.wait_count = 12'd0;
          nxt.lines      = drive(1'b0, 1'b0, 1'b0);
          nxt.phase      = PH_SP_A;
        end else begin
          nxt.poll_count = cur.poll_count + 8'd1;
        end
      end
      PH_RD_LOW: begin
        nxt.wait_count = wc_after;
        if (expired) begin
          nxt.lines = drive(1'b1, 1'b1, 1'b1);
          nxt.phase = PH_RD_HIGH;
        end
      end
      PH_RD_HIGH: begin
        nxt.wait_count = wc_after;
        // Sample on the first tick after SCL rises.
        if (cur.wait_count == 12'd0) begin
          nxt.shift_data = {cur.shift_data[6:0], tick.sda_in};
        end
        if (expired) begin
          if (cur.bit_index == 3'd7) begin
            nxt.lines = drive(1'b0, ~cur.ack_choice, 1'b0);
            nxt.phase = PH_RA_LOW;
          end else begin
            nxt.bit_index = cur.bit_index + 3'd1;
            nxt.lines     = drive(1'b0, 1'b1, 1'b1);
            nxt.phase     = PH_RD_LOW;
          end
        end
      end
      PH_RA_LOW: begin
        nxt.wait_count = wc_after;
        if (expired) begin
          nxt.lines = drive(1'b1, ~cur.ack_choice, 1'b0);
          nxt.phase = PH_RA_HIGH;
        end
      end
      PH_RA_HIGH: begin
        nxt.wait_count = wc_after;
        if (expired) begin
          nxt.lines   = drive(1'b0, ~cur.ack_choice, 1'b0);
          nxt.rx_hold = cur.shift_data;
          nxt.phase   = PH_IDLE;
          done        = 1'b1;
        end
      end
      default: begin
        nxt.phase = PH_IDLE;
      end
    endcase
  end

endmodule

FILE: src/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master that runs start, stop, byte write and byte read sequences.
// ----------------------------------------------------------------------------
// Each input word is one timing tick: it carries an optional command and the
// sampled SDA level. The engine answers every tick with one output word that
// holds the SCL and SDA line controls, the ready and done flags, the last
// received byte and the NACK flag of the last write.
// A word accepted at one clock edge produces its output word in the output
// register at that same edge, and m_tvalid rises at that edge as well.
// Throughput is one word per cycle: the tick logic is a single pass from the
// state registers to the next state, and s_tready stays high as long as the
// output register is empty or being drained in the same cycle.
// When the receiver holds m_tready low, the output word is kept and s_tready
// drops, so no tick is lost and the bus timing simply pauses.
// Every timed bus phase lasts half_period ticks, one if zero; a write waits
// for ACK over up to ack_timeout + 1 polls, then flags NACK and sends a stop.
// Reset returns the sequencer to idle with SCL and SDA driven high, clears the
// received byte and the NACK flag and restores the configuration defaults.
// Configuration is written through cfg_we, cfg_index and cfg_data while idle.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
  input  logic        clk,
  input  logic        rst,
  // Tick words in. tdata from bit 0: cmd_valid, action[1:0], tx_byte[7:0],
  // send_ack, sda_in, three zero pad bits.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  // Result words out. tdata from bit 0: scl_level, sda_level, sda_listen,
  // ready_res, done_res, rx_byte[7:0], nack, two zero pad bits.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);
  import i2cm_pkg::*;

  logic [11:0] half_period;
  logic [7:0]  ack_timeout;
  eng_state_t  state;
  eng_state_t  state_next;
  tick_t       tick;
  logic        done;
  logic        accept;
  logic [15:0] result_next;

  // The output register is the only thing between the two sides.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign tick.cmd_valid = s_tdata[0];
  assign tick.action    = s_tdata[2:1];
  assign tick.tx_byte   = s_tdata[10:3];
  assign tick.send_ack  = s_tdata[11];
  assign tick.sda_in    = s_tdata[12];

  i2cm_fsm u_fsm (
    .cur         (state),
    .tick        (tick),
    .half_period (half_period),
    .ack_timeout (ack_timeout),
    .nxt         (state_next),
    .done        (done)
  );

  // The output reflects the state after this tick.
  assign result_next = {2'b00,
                        state_next.nack_hold,
                        state_next.rx_hold,
                        done,
                        (state_next.phase == PH_IDLE),
                        state_next.lines.listen,
                        state_next.lines.sda,
                        state_next.lines.scl};

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RESET;
      ack_timeout <= ACK_TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HALF_PERIOD: half_period <= cfg_data;
        CFG_ACK_TIMEOUT: ack_timeout <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= PH_IDLE;
      state.bit_index  <= 3'd0;
      state.shift_data <= 8'd0;
      state.wait_count <= 12'd0;
      state.poll_count <= 8'd0;
      state.ack_choice <= 1'b0;
      state.lines      <= drive(1'b1, 1'b1, 1'b0);
      state.rx_hold    <= 8'd0;
      state.nack_hold  <= 1'b0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= result_next;
    end
  end

  // A finished command always leaves the sequencer idle.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> m_tdata[3])
    else $error("done reported while sequencer busy");

  // A released SDA line must read back as a one.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1])
    else $error("SDA released but drive value low");

  // Every accepted tick leaves a result word behind.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted tick produced no result word");

  // The sequencer only moves on accepted ticks.
  assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(state.phase))
    else $error("phase changed without an accepted tick");

endmodule

FILE: test/tb_i2c_master_byte_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_byte_engine
// Self-checking stream testbench for the I2C master byte engine.
// ----------------------------------------------------------------------------
// Every input word is one bus tick. The bench keeps its own cycle model of the
// sequencer, predicts the output word of each accepted tick and compares the
// words that come back field by field. A small slave model answers ACK polls
// on the fly, so writes see an ACK after a chosen number of polls or never.
// Directed tests cover reset values, half period and timeout extremes, and
// every command. Random transfers (start, address, data bytes, stop) follow,
// with stray commands and quiet ticks mixed in, under three idling patterns.
// ----------------------------------------------------------------------------
module tb_i2c_master_byte_engine;
  import i2cm_pkg::*;

  localparam int LIMIT_CYCLES = 600_000;
  localparam int DRAIN_LIMIT  = 20_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;     // cmd_valid, action[1:0], tx_byte[7:0], send_ack, sda_in, pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;     // scl, sda, listen, ready, done, rx_byte[7:0], nack, pad
  logic        cfg_we;
  logic        cfg_index;
  logic [11:0] cfg_data;

  // One output word as the engine should present it.
  typedef struct packed {
    logic       nack;
    logic [7:0] rx_byte;
    logic       done;
    logic       ready;
    logic       listen;
    logic       sda;
    logic       scl;
  } bus_word_t;

  i2c_master_byte_engine DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Bookkeeping shared by the stimulus and the checker.
  bus_word_t expected_words[$];
  int        errors;
  int        ticks_sent;
  int        commands_issued;
  int        words_checked;
  int        nack_events;
  int        src_idle_pct;
  int        sink_idle_pct;
  int        busy_noise_pct;
  int        slave_ack_delay;   // polls held high before the slave pulls SDA low, -1 never

  // Shadow copy of the engine: configuration and sequencer state.
  logic [11:0] half_cfg;
  logic [7:0]  timeout_cfg;
  logic [3:0]  seq_phase;
  logic [2:0]  bit_pos;
  logic [7:0]  shreg;
  logic [11:0] wait_ticks;
  logic [7:0]  polls;
  logic        ack_reply;
  logic        line_scl;
  logic        line_sda;
  logic        line_listen;
  logic [7:0]  rx_last;
  logic        nack_last;

  // A released SDA line is always reported as a one.
  function automatic void set_lines(input logic scl, input logic sda, input logic listen);
    line_scl    = scl;
    line_sda    = sda | listen;
    line_listen = listen;
  endfunction

  // Counts one tick of the current phase. A zero half period still lasts one tick.
  function automatic logic half_elapsed();
    logic [11:0] h;
    h = (half_cfg == 12'd0) ? 12'd1 : half_cfg;
    wait_ticks = wait_ticks + 12'd1;
    if (wait_ticks >= h) begin
      wait_ticks = 12'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the shadow engine by one tick and returns the output word it shows.
  function automatic bus_word_t advance_bus(input tick_t t);
    bus_word_t w;
    logic      fin;
    fin = 1'b0;
    case (seq_phase)
      PH_IDLE: begin
        if (t.cmd_valid) begin
          wait_ticks = 12'd0;
          bit_pos    = 3'd0;
          case (t.action)
            ACT_START: begin
              set_lines(1'b1, 1'b1, 1'b0);
              seq_phase = PH_ST_A;
            end
            ACT_STOP: begin
              set_lines(1'b0, 1'b0, 1'b0);
              seq_phase = PH_SP_A;
            end
            ACT_WRITE: begin
              shreg = t.tx_byte;
              set_lines(1'b0, shreg[7], 1'b0);
              seq_phase = PH_WR_SET;
            end
            default: begin
              shreg     = 8'd0;
              ack_reply = t.send_ack;
              set_lines(1'b0, 1'b1, 1'b1);
              seq_phase = PH_RD_LOW;
            end
          endcase
        end
      end
      PH_ST_A: begin
        if (half_elapsed()) begin
          set_lines(1'b1, 1'b0, 1'b0);
          seq_phase = PH_ST_B;
        end
      end
      PH_ST_B: begin
        if (half_elapsed()) begin
          set_lines(1'b0, 1'b0, 1'b0);
          seq_phase = PH_IDLE;
          fin = 1'b1;
        end
      end
      PH_SP_A: begin
        if (half_elapsed()) begin
          set_lines(1'b1, 1'b0, 1'b0);
          seq_phase = PH_SP_B;
        end
      end
      PH_SP_B: begin
        if (half_elapsed()) begin
          set_lines(1'b1, 1'b1, 1'b0);
          seq_phase = PH_IDLE;
          fin = 1'b1;
        end
      end
      PH_WR_SET: begin
        if (half_elapsed()) begin
          set_lines(1'b1, shreg[7], 1'b0);
          seq_phase = PH_WR_HIGH;
        end
      end
      PH_WR_HIGH: begin
        if (half_elapsed()) begin
          set_lines(1'b0, shreg[7], 1'b0);
          seq_phase = PH_WR_LOW;
        end
      end
      PH_WR_LOW: begin
        if (half_elapsed()) begin
          if (bit_pos == 3'd7) begin
            // Last bit out: release SDA and raise SCL for the ACK slot.
            set_lines(1'b1, 1'b1, 1'b1);
            seq_phase = PH_AK_WAIT;
          end else begin
            bit_pos = bit_pos + 3'd1;
            shreg   = {shreg[6:0], 1'b0};
            set_lines(1'b0, shreg[7], 1'b0);
            seq_phase = PH_WR_SET;
          end
        end
      end
      PH_AK_WAIT: begin
        if (half_elapsed()) begin
          polls     = 8'd0;
          seq_phase = PH_AK_POLL;
        end
      end
      PH_AK_POLL: begin
        if (!t.sda_in) begin
          set_lines(1'b0, 1'b1, 1'b1);
          nack_last = 1'b0;
          seq_phase = PH_IDLE;
          fin = 1'b1;
        end else if (polls >= timeout_cfg) begin
          // No ACK in time: flag it and fall into the stop sequence.
          nack_last  = 1'b1;
          wait_ticks = 12'd0;
          set_lines(1'b0, 1'b0, 1'b0);
          seq_phase  = PH_SP_A;
          nack_events++;
        end else begin
          polls = polls + 8'd1;
        end
      end
      PH_RD_LOW: begin
        if (half_elapsed()) begin
          set_lines(1'b1, 1'b1, 1'b1);
          seq_phase = PH_RD_HIGH;
        end
      end
      PH_RD_HIGH: begin
        // The bit is taken on the first tick after SCL rises.
        if (wait_ticks == 12'd0) shreg = {shreg[6:0], t.sda_in};
        if (half_elapsed()) begin
          if (bit_pos == 3'd7) begin
            set_lines(1'b0, ~ack_reply, 1'b0);
            seq_phase = PH_RA_LOW;
          end else begin
            bit_pos = bit_pos + 3'd1;
            set_lines(1'b0, 1'b1, 1'b1);
            seq_phase = PH_RD_LOW;
          end
        end
      end
      PH_RA_LOW: begin
        if (half_elapsed()) begin
          set_lines(1'b1, ~ack_reply, 1'b0);
          seq_phase = PH_RA_HIGH;
        end
      end
      PH_RA_HIGH: begin
        if (half_elapsed()) begin
          set_lines(1'b0, ~ack_reply, 1'b0);
          rx_last   = shreg;
          seq_phase = PH_IDLE;
          fin = 1'b1;
        end
      end
      default: seq_phase = PH_IDLE;
    endcase
    w.scl     = line_scl;
    w.sda     = line_sda;
    w.listen  = line_listen;
    w.ready   = (seq_phase == PH_IDLE);
    w.done    = fin;
    w.rx_byte = rx_last;
    w.nack    = nack_last;
    return w;
  endfunction

  // The slave model: during the ACK poll it holds SDA high for the planned
  // number of polls, elsewhere the line level is random.
  function automatic logic sda_pin();
    if (seq_phase == PH_AK_POLL)
      return (slave_ack_delay < 0 || int'(polls) < slave_ack_delay) ? 1'b1 : 1'b0;
    return 1'($urandom_range(1));
  endfunction

  function automatic tick_t make_tick(input logic with_cmd);
    tick_t t;
    t.cmd_valid = with_cmd;
    t.action    = 2'($urandom_range(3));
    t.tx_byte   = 8'($urandom);
    t.send_ack  = 1'($urandom_range(1));
    t.sda_in    = sda_pin();
    return t;
  endfunction

  function automatic int pick_ack_delay();
    if ($urandom_range(99) < 20) return -1;
    return $urandom_range(int'(timeout_cfg) + 1);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // Sends one tick word, with random gaps before it, and records its prediction.
  task automatic send_tick(input tick_t t);
    @(negedge clk);
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, t.sda_in, t.send_ack, t.tx_byte, t.action, t.cmd_valid};
    do @(posedge clk); while (!s_tready);
    ticks_sent++;
    expected_words.push_back(advance_bus(t));
  endtask

  // Issues one command while idle and keeps ticking until the engine is idle
  // again. Ticks on the way may carry stray commands, which must be ignored.
  task automatic run_command(input logic [1:0] act, input logic [7:0] data,
                             input logic ack_back, input int ack_delay);
    tick_t t;
    slave_ack_delay = ack_delay;
    t = make_tick(1'b1);
    t.action   = act;
    t.tx_byte  = data;
    t.send_ack = ack_back;
    send_tick(t);
    commands_issued++;
    while (seq_phase != PH_IDLE)
      send_tick(make_tick($urandom_range(99) < busy_noise_pct));
  endtask

  // Stops sending and waits until every predicted word has been checked.
  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (expected_words.size() != 0) begin
      $error("%0d output words never arrived", expected_words.size());
      errors++;
      expected_words.delete();
    end
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [11:0] value);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_HALF_PERIOD) half_cfg = value;
    else timeout_cfg = value[7:0];
  endtask

  task automatic configure(input logic [11:0] half, input logic [11:0] timeout);
    write_reg(CFG_HALF_PERIOD, half);
    write_reg(CFG_ACK_TIMEOUT, timeout);
  endtask

  task automatic set_idling(input int src_pct, input int sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
  endtask

  // Reset defaults: quiet ticks, then a start at the reset half period.
  task automatic test_reset_defaults();
    repeat (3) send_tick(make_tick(1'b0));
    run_command(ACT_START, 8'h00, 1'b0, -1);
    drain_results();
  endtask

  // A longer and a zero half period; zero must behave as one tick.
  task automatic test_half_period_extremes();
    configure(12'd9, 12'd250);
    run_command(ACT_START, 8'h00, 1'b0, -1);
    run_command(ACT_STOP, 8'h00, 1'b0, -1);
    configure(12'd0, 12'd250);
    run_command(ACT_START, 8'h00, 1'b0, -1);
    run_command(ACT_WRITE, 8'hFF, 1'b0, 0);
    run_command(ACT_READ, 8'h00, 1'b1, -1);
    run_command(ACT_STOP, 8'h00, 1'b0, -1);
    drain_results();
  endtask

  // ACK polling at the timeout limits, including a zero timeout where the
  // first high poll already fails, and upper data bits that do not fit.
  task automatic test_ack_timeout();
    configure(12'd1, 12'd0);
    run_command(ACT_WRITE, 8'h00, 1'b0, -1);
    run_command(ACT_WRITE, 8'h80, 1'b0, 0);
    write_reg(CFG_ACK_TIMEOUT, 12'h0FF);
    run_command(ACT_WRITE, 8'h5A, 1'b0, 255);
    write_reg(CFG_ACK_TIMEOUT, 12'hF03);
    run_command(ACT_WRITE, 8'hC3, 1'b1, 4);
    drain_results();
  endtask

  // Reads with ACK and NACK, and a stop that must keep the NACK flag and the
  // received byte. Busy ticks carry many stray commands here.
  task automatic test_byte_commands();
    configure(12'd1, 12'd4);
    busy_noise_pct = 40;
    run_command(ACT_READ, 8'h00, 1'b1, -1);
    run_command(ACT_READ, 8'hFF, 1'b0, -1);
    run_command(ACT_STOP, 8'h00, 1'b0, -1);
    run_command(ACT_WRITE, 8'h01, 1'b0, 2);
    run_command(ACT_STOP, 8'h00, 1'b1, -1);
    run_command(ACT_START, 8'hFF, 1'b1, -1);
    run_command(ACT_READ, 8'h00, 1'b0, -1);
    busy_noise_pct = 10;
    drain_results();
  endtask

  // A well-formed transfer: start, address byte, up to three data bytes, stop.
  task automatic random_transfer();
    int n;
    n = $urandom_range(3);
    run_command(ACT_START, 8'($urandom), 1'($urandom_range(1)), -1);
    run_command(ACT_WRITE, 8'($urandom), 1'($urandom_range(1)), pick_ack_delay());
    repeat (n) begin
      if ($urandom_range(1))
        run_command(ACT_WRITE, 8'($urandom), 1'($urandom_range(1)), pick_ack_delay());
      else
        run_command(ACT_READ, 8'($urandom), 1'($urandom_range(1)), -1);
    end
    run_command(ACT_STOP, 8'($urandom), 1'($urandom_range(1)), -1);
  endtask

  // Mostly transfers; the rest are lone commands in any order and quiet ticks.
  task automatic test_random_traffic(input int goal);
    int first_tick;
    first_tick = ticks_sent;
    while (ticks_sent - first_tick < goal) begin
      if ($urandom_range(99) < 75) begin
        random_transfer();
      end else if ($urandom_range(1)) begin
        run_command(2'($urandom_range(3)), 8'($urandom), 1'($urandom_range(1)),
                    pick_ack_delay());
      end else begin
        repeat ($urandom_range(6, 1)) send_tick(make_tick(1'b0));
      end
    end
    drain_results();
  endtask

  // Each returned word is checked against the oldest prediction.
  always @(posedge clk) begin
    bus_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        $error("output word %h arrived with nothing expected", m_tdata);
        errors++;
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        check_field("scl_level", want.scl, m_tdata[0]);
        check_field("sda_level", want.sda, m_tdata[1]);
        check_field("sda_listen", want.listen, m_tdata[2]);
        check_field("ready_res", want.ready, m_tdata[3]);
        check_field("done_res", want.done, m_tdata[4]);
        check_field("rx_byte", want.rx_byte, m_tdata[12:5]);
        check_field("nack", want.nack, m_tdata[13]);
        check_field("pad", 0, m_tdata[15:14]);
      end
    end
  end

  // The receiver stalls at random according to the current idling pattern.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  initial begin
    s_tvalid  = 1'b0;
    s_tdata   = 16'd0;
    cfg_we    = 1'b0;
    cfg_index = CFG_HALF_PERIOD;
    cfg_data  = 12'd0;
    errors          = 0;
    ticks_sent      = 0;
    commands_issued = 0;
    words_checked   = 0;
    nack_events     = 0;
    busy_noise_pct  = 10;
    slave_ack_delay = -1;
    set_idling(24, 78);

    // Shadow engine starts in its reset state.
    half_cfg    = HALF_PERIOD_RESET;
    timeout_cfg = ACK_TIMEOUT_RESET;
    seq_phase   = PH_IDLE;
    bit_pos     = 3'd0;
    shreg       = 8'd0;
    wait_ticks  = 12'd0;
    polls       = 8'd0;
    ack_reply   = 1'b0;
    line_scl    = 1'b1;
    line_sda    = 1'b1;
    line_listen = 1'b0;
    rx_last     = 8'd0;
    nack_last   = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    set_idling(0, 0);
    test_half_period_extremes();
    set_idling(24, 78);
    test_ack_timeout();
    set_idling(78, 24);
    test_byte_commands();

    // Random traffic: small half periods keep many commands in the budget,
    // and short timeouts make both ACK and NACK outcomes common.
    set_idling(24, 78);
    configure(12'd1, 12'd3);
    test_random_traffic(30);
    configure(12'd2, 12'd0);
    test_random_traffic(30);
    set_idling(78, 24);
    configure(12'd0, 12'd5);
    test_random_traffic(30);
    configure(12'd1, 12'd1);
    test_random_traffic(30);
    set_idling(0, 0);
    configure(12'd0, 12'd12);
    test_random_traffic(30);
    configure(12'd1, 12'd2);
    test_random_traffic(30);

    drain_results();
    $display("Covered %0d ticks and %0d commands, %0d of them ending in a write NACK.",
             ticks_sent, commands_issued, nack_events);
    $display("Checked %0d output words with %0d errors.", words_checked, errors);
    if (errors == 0) begin
      $display("i2c_master_byte_engine regression: pass");
    end else begin
      $display("i2c_master_byte_engine regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(LIMIT_CYCLES * 12);
    $display("Watchdog expired after %0d cycles.", LIMIT_CYCLES);
    $display("i2c_master_byte_engine regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
src/i2cm_pkg.sv
src/i2cm_fsm.sv
src/i2c_master_byte_engine.sv
test/tb_i2c_master_byte_engine.sv
